// ===== src/dts_pkg.sv =====
// Package for the deadline task scheduler: operation codes, sequencer states,
// fixed field widths and the control structs passed between top level and cells.
// Depends on nothing; used by dts_cell and deadline_task_scheduler_unit.
`default_nettype none

package dts_pkg;

  // Fixed widths of the channel fields.
  localparam int unsigned OP_W       = 3;
  localparam int unsigned IN_SLOT_W  = 4;
  localparam int unsigned DELAY_W    = 32;
  localparam int unsigned OUT_SLOT_W = 4;
  localparam int unsigned OUT_TIME_W = 32;

  // Upper bound on launches produced by one tick.
  localparam int unsigned MAX_LAUNCH = 16;

  // Operation codes carried by the op field.
  typedef enum logic [OP_W-1:0] {
    OP_SCHEDULE = 3'd0,
    OP_REPEAT   = 3'd1,
    OP_REMOVE   = 3'd2,
    OP_FINISH   = 3'd3,
    OP_TICK     = 3'd4
  } op_e;

  // Sequencer states of the top level.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // Slot operation addressed to one cell.
  typedef struct packed {
    logic wr;
    op_e  op;
  } cell_cmd_t;

  // Ranking controls broadcast to all cells.
  typedef struct packed {
    logic load;
    logic shift;
    logic cmp;
  } scan_ctl_t;

endpackage

`default_nettype wire

// ===== src/dts_cell.sv =====
// One task slot of the scheduler: deadline, period and flags, plus one stage
// of the ranking ring that counts how many due slots launch ahead of it.
// Depends on dts_pkg.
`default_nettype none

module dts_cell #(
  parameter int unsigned SLOT_W    = 4,
  parameter int unsigned TIME_BITS = 32,
  parameter int unsigned CELL_IDX  = 0
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire dts_pkg::cell_cmd_t    cmd_i,
  input  wire logic [TIME_BITS-1:0]  delay_i,
  input  wire logic [TIME_BITS-1:0]  now_i,
  input  wire dts_pkg::scan_ctl_t    ctl_i,
  input  wire logic                  disarm_i,
  input  wire logic                  ring_due_i,
  input  wire logic [TIME_BITS-1:0]  ring_age_i,
  input  wire logic [SLOT_W-1:0]     ring_idx_i,
  output logic                       ring_due_o,
  output logic [TIME_BITS-1:0]       ring_age_o,
  output logic [SLOT_W-1:0]          ring_idx_o,
  output logic                       due_o,
  output logic [SLOT_W-1:0]          rank_o,
  output logic [TIME_BITS-1:0]       deadline_o
);

  localparam logic [SLOT_W-1:0] OwnIdx = SLOT_W'(CELL_IDX);

  logic [TIME_BITS-1:0] deadline_q, deadline_d;
  logic [TIME_BITS-1:0] period_q, period_d;
  logic                 armed_q, armed_d;
  logic                 periodic_q, periodic_d;
  logic [TIME_BITS-1:0] own_age_q, own_age_d;
  logic                 own_due_q, own_due_d;
  logic                 circ_due_q, circ_due_d;
  logic [TIME_BITS-1:0] circ_age_q, circ_age_d;
  logic [SLOT_W-1:0]    circ_idx_q, circ_idx_d;
  logic [SLOT_W-1:0]    rank_q, rank_d;
  logic [TIME_BITS-1:0] age_now;
  logic                 beats;

  // Age of the deadline against the current time; due while in the recent half.
  assign age_now = now_i - deadline_q;

  // The passing slot launches first if it is older, or as old with lower index.
  assign beats = ring_due_i &&
                 ((ring_age_i > own_age_q) ||
                  ((ring_age_i == own_age_q) && (ring_idx_i < OwnIdx)));

  // Slot operations, launch disarm and the ranking stage.
  always_comb begin
    deadline_d = deadline_q;
    period_d   = period_q;
    armed_d    = armed_q;
    periodic_d = periodic_q;
    own_age_d  = own_age_q;
    own_due_d  = own_due_q;
    circ_due_d = circ_due_q;
    circ_age_d = circ_age_q;
    circ_idx_d = circ_idx_q;
    rank_d     = rank_q;

    if (cmd_i.wr) begin
      case (cmd_i.op)
        dts_pkg::OP_SCHEDULE: begin
          deadline_d = now_i + delay_i;
          armed_d    = 1'b1;
        end
        dts_pkg::OP_REPEAT: begin
          if (!armed_q) begin
            deadline_d = now_i + delay_i;
            armed_d    = 1'b1;
          end
          period_d   = delay_i;
          periodic_d = 1'b1;
        end
        dts_pkg::OP_REMOVE: begin
          armed_d    = 1'b0;
          periodic_d = 1'b0;
        end
        dts_pkg::OP_FINISH: begin
          if (periodic_q) begin
            deadline_d = now_i + period_q;
            armed_d    = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end

    if (disarm_i) begin
      armed_d = 1'b0;
    end

    // Capture this slot's standing at the new time and start the ring with it.
    if (ctl_i.load) begin
      own_age_d  = age_now;
      own_due_d  = armed_q && !age_now[TIME_BITS-1];
      circ_due_d = armed_q && !age_now[TIME_BITS-1];
      circ_age_d = age_now;
      circ_idx_d = OwnIdx;
      rank_d     = '0;
    end else if (ctl_i.shift) begin
      circ_due_d = ring_due_i;
      circ_age_d = ring_age_i;
      circ_idx_d = ring_idx_i;
      if (ctl_i.cmp && beats) begin
        rank_d = rank_q + SLOT_W'(1);
      end
    end
  end

  // Flags and ranking control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      armed_q    <= 1'b0;
      periodic_q <= 1'b0;
      own_due_q  <= 1'b0;
      circ_due_q <= 1'b0;
      rank_q     <= '0;
    end else begin
      armed_q    <= armed_d;
      periodic_q <= periodic_d;
      own_due_q  <= own_due_d;
      circ_due_q <= circ_due_d;
      rank_q     <= rank_d;
    end
  end

  // Time values and ring payload.
  always_ff @(posedge clk_i) begin
    deadline_q <= deadline_d;
    period_q   <= period_d;
    own_age_q  <= own_age_d;
    circ_age_q <= circ_age_d;
    circ_idx_q <= circ_idx_d;
  end

  assign ring_due_o = circ_due_q;
  assign ring_age_o = circ_age_q;
  assign ring_idx_o = circ_idx_q;
  assign due_o      = own_due_q;
  assign rank_o     = rank_q;
  assign deadline_o = deadline_q;

endmodule

`default_nettype wire

// ===== src/deadline_task_scheduler_unit.sv =====
// Top level of the deadline task scheduler: tick counter, sequencer, the ring
// of slot cells and the launch output register.
// Depends on dts_pkg and dts_cell.
//
//   Channel  | Direction | Handshake               | Fields
//   ---------+-----------+-------------------------+----------------------------------
//   in       | input     | in_valid_i/in_stall_o   | op_i, slot_i, delay_ticks_i
//   out      | output    | out_valid_o/out_stall_i | launched_slot_o, due_time_o, last_o
//
// A tick ranks the due slots around the ring of cells in order: its transfer,
// one load step and one ring step per slot. Then it emits one launch per
// cycle while the output is not stalled, at most 16, and passes through the
// emit state even when nothing is due.
// Reset clears the tick counter and every armed and periodic flag at once.
// in_stall_o is high while a tick is ranked or launched; a pending output
// transfer does not block slot operations.
`default_nettype none

module deadline_task_scheduler_unit #(
  parameter int unsigned SLOTS     = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic [dts_pkg::OP_W-1:0]          op_i,
  input  wire logic [dts_pkg::IN_SLOT_W-1:0]     slot_i,
  input  wire logic [dts_pkg::DELAY_W-1:0]       delay_ticks_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic [dts_pkg::OUT_SLOT_W-1:0]         launched_slot_o,
  output logic [dts_pkg::OUT_TIME_W-1:0]         due_time_o,
  output logic                                   last_o
);

  localparam int unsigned SlotW   = $clog2(SLOTS);
  localparam int unsigned CntW    = SlotW + 1;
  localparam int unsigned SelW    = (SlotW > dts_pkg::IN_SLOT_W) ? SlotW : dts_pkg::IN_SLOT_W;
  localparam int unsigned TimeExW = (TIME_BITS > dts_pkg::DELAY_W) ? TIME_BITS : dts_pkg::DELAY_W;
  localparam logic [SlotW-1:0] LastStep = SlotW'(SLOTS - 1);

  dts_pkg::state_e    state_q, state_d;
  logic [TIME_BITS-1:0] now_q, now_d;
  logic [SlotW-1:0]   step_q, step_d;
  logic [CntW-1:0]    ndue_q, ndue_d;
  logic [CntW-1:0]    emit_q, emit_d;
  logic               out_valid_q, out_valid_d;
  logic [dts_pkg::OUT_SLOT_W-1:0] out_slot_q, out_slot_d;
  logic [dts_pkg::OUT_TIME_W-1:0] out_time_q, out_time_d;
  logic               out_last_q, out_last_d;

  logic               in_xfer;
  dts_pkg::op_e       op;
  dts_pkg::scan_ctl_t ctl;
  logic [TimeExW-1:0] delay_ext;
  logic [TIME_BITS-1:0] delay;
  logic [SelW-1:0]    slot_ext;
  logic [CntW-1:0]    limit;
  logic               emit_go;
  logic [SlotW-1:0]   hit_idx;
  logic [TIME_BITS-1:0] hit_deadline;
  logic [SelW-1:0]    hit_idx_ext;
  logic [TimeExW-1:0] hit_time_ext;

  dts_pkg::cell_cmd_t   cmd      [SLOTS];
  logic                 disarm   [SLOTS];
  logic                 ring_due [SLOTS];
  logic [TIME_BITS-1:0] ring_age [SLOTS];
  logic [SlotW-1:0]     ring_idx [SLOTS];
  logic                 cell_due [SLOTS];
  logic [SlotW-1:0]     cell_rank[SLOTS];
  logic [TIME_BITS-1:0] cell_dl  [SLOTS];

  // Input transfer and field conditioning.
  assign in_stall_o = (state_q != dts_pkg::ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign op         = dts_pkg::op_e'(op_i);
  assign delay_ext  = TimeExW'(delay_ticks_i);
  assign delay      = delay_ext[TIME_BITS-1:0];
  assign slot_ext   = SelW'(slot_i);

  // Launch count of this tick is capped.
  assign limit = (32'(ndue_q) > 32'(dts_pkg::MAX_LAUNCH)) ?
                 CntW'(dts_pkg::MAX_LAUNCH) : ndue_q;

  // The slot whose rank matches the launch counter; ranks of due slots are distinct.
  always_comb begin
    hit_idx      = '0;
    hit_deadline = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (cell_due[i] && (CntW'(cell_rank[i]) == emit_q)) begin
        hit_idx      = hit_idx | SlotW'(i);
        hit_deadline = hit_deadline | cell_dl[i];
      end
    end
  end

  assign hit_idx_ext  = SelW'(hit_idx);
  assign hit_time_ext = TimeExW'(hit_deadline);

  // Sequencer: next state, counters, ring controls and output register.
  always_comb begin
    state_d     = state_q;
    now_d       = now_q;
    step_d      = step_q;
    ndue_d      = ndue_q;
    emit_d      = emit_q;
    out_valid_d = out_valid_q;
    out_slot_d  = out_slot_q;
    out_time_d  = out_time_q;
    out_last_d  = out_last_q;
    ctl         = '0;
    emit_go     = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      dts_pkg::ST_IDLE: begin
        if (in_xfer && (op == dts_pkg::OP_TICK)) begin
          now_d   = now_q + TIME_BITS'(1);
          state_d = dts_pkg::ST_LOAD;
        end
      end
      dts_pkg::ST_LOAD: begin
        ctl.load = 1'b1;
        step_d   = '0;
        ndue_d   = '0;
        state_d  = dts_pkg::ST_SCAN;
      end
      dts_pkg::ST_SCAN: begin
        // Each slot passes cell 0 once, so due slots are counted there.
        ctl.shift = 1'b1;
        ctl.cmp   = (step_q != LastStep);
        ndue_d    = ndue_q + CntW'(ring_due[0]);
        step_d    = step_q + SlotW'(1);
        if (step_q == LastStep) begin
          emit_d  = '0;
          state_d = dts_pkg::ST_EMIT;
        end
      end
      dts_pkg::ST_EMIT: begin
        if (limit == '0) begin
          state_d = dts_pkg::ST_IDLE;
        end else if (!out_valid_q || !out_stall_i) begin
          emit_go     = 1'b1;
          out_valid_d = 1'b1;
          out_slot_d  = hit_idx_ext[dts_pkg::OUT_SLOT_W-1:0];
          out_time_d  = hit_time_ext[dts_pkg::OUT_TIME_W-1:0];
          out_last_d  = (emit_q + CntW'(1) == limit);
          emit_d      = emit_q + CntW'(1);
          if (emit_q + CntW'(1) == limit) begin
            state_d = dts_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = dts_pkg::ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dts_pkg::ST_IDLE;
      now_q       <= '0;
      step_q      <= '0;
      ndue_q      <= '0;
      emit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      now_q       <= now_d;
      step_q      <= step_d;
      ndue_q      <= ndue_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output payload register.
  always_ff @(posedge clk_i) begin
    out_slot_q <= out_slot_d;
    out_time_q <= out_time_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o     = out_valid_q;
  assign launched_slot_o = out_slot_q;
  assign due_time_o      = out_time_q;
  assign last_o          = out_last_q;

  // Ring of slot cells; each stage takes the ranking data of its left neighbor.
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    assign cmd[g].wr = in_xfer && (op != dts_pkg::OP_TICK) && (slot_ext == SelW'(g));
    assign cmd[g].op = op;
    assign disarm[g] = emit_go && cell_due[g] && (CntW'(cell_rank[g]) == emit_q);

    dts_cell #(
      .SLOT_W   (SlotW),
      .TIME_BITS(TIME_BITS),
      .CELL_IDX (g)
    ) u_cell (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .cmd_i     (cmd[g]),
      .delay_i   (delay),
      .now_i     (now_q),
      .ctl_i     (ctl),
      .disarm_i  (disarm[g]),
      .ring_due_i(ring_due[(g + SLOTS - 1) % SLOTS]),
      .ring_age_i(ring_age[(g + SLOTS - 1) % SLOTS]),
      .ring_idx_i(ring_idx[(g + SLOTS - 1) % SLOTS]),
      .ring_due_o(ring_due[g]),
      .ring_age_o(ring_age[g]),
      .ring_idx_o(ring_idx[g]),
      .due_o     (cell_due[g]),
      .rank_o    (cell_rank[g]),
      .deadline_o(cell_dl[g])
    );
  end

endmodule

`default_nettype wire
